>>> design/indexed_list_insert_remove_core_assert.svh
// Assertion macros used by the checker in ilir_chk.sv.
`ifndef INDEXED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ILIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/ilir_pkg.sv
package ilir_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = 5;
  localparam int ECNT_W   = 5;
  // common width for comparing an index against the count
  localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] games;
    logic signed [31:0] tally;
    logic        [63:0] score;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

>>> design/ilir_in_if.sv
interface ilir_in_if import ilir_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [IDX_W-1:0]        index;
  logic signed [31:0]      games;
  logic signed [31:0]      tally;
  logic [63:0]             score_bits;

  modport source (output valid, command, index, games, tally, score_bits, input ready);
  modport sink   (input valid, command, index, games, tally, score_bits, output ready);
endinterface

>>> design/ilir_out_if.sv
interface ilir_out_if import ilir_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [31:0]      read_games;
  logic signed [31:0]      read_tally;
  logic [63:0]             read_score_bits;
  logic [ECNT_W-1:0]       entry_count;

  modport source (output valid, status, read_games, read_tally, read_score_bits,
                  entry_count, input ready);
  modport sink   (input valid, status, read_games, read_tally, read_score_bits,
                  entry_count, output ready);
endinterface

>>> design/ilir_ram.sv
module ilir_ram #(
  parameter int DW    = 128,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/indexed_list_insert_remove_core.sv
// Channel  Dir  Modport             Beat contents
// in_i     in   ilir_in_if.sink     command, index, games, tally, score_bits
// out_o    out  ilir_out_if.source  status, read_*, entry_count
//
// One command is in work at a time; the records sit in one RAM with one write
// and one registered read port. Append, read, insert at the end, remove of the
// last record and any rejected command go from accept straight to S_DONE,
// where the result beat is loaded. Insert below the end passes S_UP and S_PUT,
// remove of an earlier record passes S_DN; each moved record takes its own
// write on the single write port. Reset clears the count and control
// registers; RAM contents stay undefined until written. A result beat waiting on
// out_o.ready holds the next command in S_DONE, with the input closed.
module indexed_list_insert_remove_core import ilir_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  ilir_in_if.sink        in_i,
  ilir_out_if.source     out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_DN,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_WRITE,
    ACT_UP,
    ACT_DN,
    ACT_READ
  } act_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;
  status_e           status_q;
  logic              rd_ok_q;
  logic [ADDR_W-1:0] pos_q;
  logic [ADDR_W-1:0] ptr_q;
  logic [ADDR_W-1:0] last_q;
  rec_t              rec_q;

  logic              out_valid_q;
  status_e           out_status_q;
  rec_t              out_rec_q;
  logic [ECNT_W-1:0] out_cnt_q;

  logic              acc;
  logic              out_load;
  logic [CMP_W-1:0]  idx_x;
  logic [CMP_W-1:0]  cnt_x;
  logic [ADDR_W-1:0] idx_a;
  logic [ADDR_W-1:0] cnt_a;
  logic              full;
  act_e              act;
  status_e           status_n;
  logic [CNT_W-1:0]  cnt_n;
  rec_t              in_rec;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  rec_t              ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [REC_W-1:0]  ram_rdata;
  rec_t              rd_rec;

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  // load the result register once it is free or being emptied
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  assign idx_x  = CMP_W'(in_i.index);
  assign cnt_x  = CMP_W'(cnt_q);
  assign idx_a  = idx_x[ADDR_W-1:0];
  assign cnt_a  = cnt_x[ADDR_W-1:0];
  assign full   = (cnt_x >= CMP_W'(CAPACITY));
  assign in_rec = '{games: in_i.games, tally: in_i.tally, score: in_i.score_bits};
  assign rd_rec = rec_t'(ram_rdata);

  // Decode the command against the current count.
  always_comb begin
    act      = ACT_NONE;
    status_n = ST_DONE;
    cnt_n    = cnt_q;
    case (cmd_e'(in_i.command))
      CMD_APPEND: begin
        if (full) begin
          status_n = ST_FULL;
        end else begin
          act   = ACT_WRITE;
          cnt_n = cnt_q + CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (idx_x > cnt_x) begin
          status_n = ST_BAD_INDEX;
        end else if (full) begin
          status_n = ST_FULL;
        end else begin
          // inserting at the end needs no shift
          act   = (idx_x == cnt_x) ? ACT_WRITE : ACT_UP;
          cnt_n = cnt_q + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (idx_x >= cnt_x) begin
          status_n = ST_BAD_INDEX;
        end else begin
          // removing the last record moves nothing
          act   = (idx_x + CMP_W'(1) == cnt_x) ? ACT_NONE : ACT_DN;
          cnt_n = cnt_q - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (idx_x >= cnt_x) begin
          status_n = ST_BAD_INDEX;
        end else begin
          act = ACT_READ;
        end
      end
      default: begin
        act = ACT_NONE;
      end
    endcase
  end

  // RAM port control: at most one write and at most one read each cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = rec_q;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (act)
            ACT_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = cnt_a;
              ram_wdata = in_rec;
            end
            ACT_UP: begin
              // fetch the top record first, so no record is overwritten before it moves
              ram_re    = 1'b1;
              ram_raddr = cnt_a - ADDR_W'(1);
            end
            ACT_DN: begin
              ram_re    = 1'b1;
              ram_raddr = idx_a + ADDR_W'(1);
            end
            ACT_READ: begin
              ram_re    = 1'b1;
              ram_raddr = idx_a;
            end
            default: begin
              ram_re = 1'b0;
            end
          endcase
        end
      end
      S_UP: begin
        // write the record fetched last cycle one slot higher
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = rd_rec;
        if (ptr_q - ADDR_W'(1) > pos_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q - ADDR_W'(2);
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = rec_q;
      end
      S_DN: begin
        // write the record fetched last cycle one slot lower
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = rd_rec;
        if (ptr_q != last_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + ADDR_W'(2);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ilir_ram #(
    .DW    (REC_W),
    .DEPTH (CAPACITY),
    .AW    (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (REC_W'(ram_wdata)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      status_q     <= ST_DONE;
      rd_ok_q      <= 1'b0;
      pos_q        <= '0;
      ptr_q        <= '0;
      last_q       <= '0;
      rec_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_DONE;
      out_rec_q    <= '0;
      out_cnt_q    <= '0;
    end else begin
      // raise the result beat on load, drop it once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            status_q <= status_n;
            rd_ok_q  <= (act == ACT_READ);
            cnt_q    <= cnt_n;
            pos_q    <= idx_a;
            rec_q    <= in_rec;
            case (act)
              ACT_UP: begin
                ptr_q   <= cnt_a;
                state_q <= S_UP;
              end
              ACT_DN: begin
                ptr_q   <= idx_a;
                last_q  <= cnt_a - ADDR_W'(2);
                state_q <= S_DN;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_UP: begin
          if (ptr_q - ADDR_W'(1) > pos_q) begin
            ptr_q <= ptr_q - ADDR_W'(1);
          end else begin
            state_q <= S_PUT;
          end
        end
        S_PUT: begin
          state_q <= S_DONE;
        end
        S_DN: begin
          if (ptr_q != last_q) begin
            ptr_q <= ptr_q + ADDR_W'(1);
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // hold here until the output register is free
          if (out_load) begin
            out_status_q <= status_q;
            out_rec_q    <= rd_ok_q ? rd_rec : '0;
            out_cnt_q    <= ECNT_W'(cnt_q);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.read_games      = out_rec_q.games;
  assign out_o.read_tally      = out_rec_q.tally;
  assign out_o.read_score_bits = out_rec_q.score;
  assign out_o.entry_count     = out_cnt_q;

endmodule

>>> design/ilir_chk.sv
`include "indexed_list_insert_remove_core_assert.svh"

module ilir_chk import ilir_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [1:0]        out_status_i,
  input logic [31:0]       out_games_i,
  input logic [31:0]       out_tally_i,
  input logic [63:0]       out_score_i,
  input logic [ECNT_W-1:0] out_count_i
);

  logic                   stall_w;
  logic                   reject_w;
  logic                   rec_zero_w;
  logic                   full_w;
  logic [ECNT_W+129:0]    out_beat_w;

  assign stall_w    = out_valid_i && !out_ready_i;
  assign reject_w   = out_valid_i && (out_status_i != ST_DONE);
  assign rec_zero_w = (out_games_i == '0) && (out_tally_i == '0) && (out_score_i == '0);
  assign full_w     = out_valid_i && (out_status_i == ST_FULL);
  assign out_beat_w = {out_status_i, out_games_i, out_tally_i, out_score_i, out_count_i};

  // a stalled result beat holds
  `ILIR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stall_w, out_valid_i && $stable(out_beat_w))

  // a rejected command never carries record data
  `ILIR_ASSERT_IMPLY(a_reject_zero, clk_i, rst_ni, reject_w, rec_zero_w)

  // full status only when the list is at capacity
  `ILIR_ASSERT_IMPLY(a_full_count, clk_i, rst_ni, full_w, out_count_i == ECNT_W'(CAPACITY))

  // one command in work at a time
  `ILIR_ASSERT_NEXT(a_one_job, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

endmodule

bind indexed_list_insert_remove_core ilir_chk u_ilir_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_status_i    (out_o.status),
  .out_games_i     (out_o.read_games),
  .out_tally_i     (out_o.read_tally),
  .out_score_i     (out_o.read_score_bits),
  .out_count_i     (out_o.entry_count)
);
